[hdl/scl_pkg.sv]
// Package for the source code lexer: token kinds, scan phases and shared types.
// Used by every module of the lexer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package scl_pkg;
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int DEPTH_BITS  = 16;
    localparam int PREFIX_DEPTH = 7;

    localparam logic [5:0] K_PLUS     = 6'd18;
    localparam logic [5:0] K_MINUS    = 6'd20;
    localparam logic [5:0] K_ARROW    = 6'd22;
    localparam logic [5:0] K_STAR     = 6'd23;
    localparam logic [5:0] K_SLASH    = 6'd25;
    localparam logic [5:0] K_LPAREN   = 6'd27;
    localparam logic [5:0] K_RPAREN   = 6'd28;
    localparam logic [5:0] K_LBRACE   = 6'd29;
    localparam logic [5:0] K_RBRACE   = 6'd30;
    localparam logic [5:0] K_LBRACKET = 6'd31;
    localparam logic [5:0] K_RBRACKET = 6'd32;
    localparam logic [5:0] K_COMMA    = 6'd33;
    localparam logic [5:0] K_SEMI     = 6'd34;
    localparam logic [5:0] K_COLON    = 6'd35;
    localparam logic [5:0] K_DOT      = 6'd36;
    localparam logic [5:0] K_DOTDOT   = 6'd37;
    localparam logic [5:0] K_EQ       = 6'd38;
    localparam logic [5:0] K_BANG     = 6'd40;
    localparam logic [5:0] K_LT       = 6'd42;
    localparam logic [5:0] K_GT       = 6'd44;
    localparam logic [5:0] K_ANDAND   = 6'd46;
    localparam logic [5:0] K_OROR     = 6'd47;
    localparam logic [5:0] K_STRING   = 6'd48;
    localparam logic [5:0] K_INT      = 6'd49;
    localparam logic [5:0] K_FLOAT    = 6'd50;
    localparam logic [5:0] K_IDENT    = 6'd51;
    localparam logic [5:0] K_ERROR    = 6'd52;
    localparam logic [5:0] K_END      = 6'd53;

    typedef enum logic [4:0] {
        PH_IDLE, PH_PLUS, PH_MINUS, PH_STAR, PH_SLASH, PH_DOT, PH_EQ, PH_BANG,
        PH_LT, PH_GT, PH_AMP, PH_PIPE, PH_STR, PH_INT, PH_INT_DOT, PH_FLOAT,
        PH_IDENT, PH_LINE, PH_BLOCK, PH_BLOCK_SLASH, PH_BLOCK_STAR
    } t_phase;

    typedef struct packed {
        logic [5:0]             kind;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } t_token;

    // Up to three tokens released by one transaction, slot 0 first.
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
        t_token     tok2;
    } t_burst;

    typedef logic [PREFIX_DEPTH*8-1:0] t_prefix;

    function automatic logic [7:0] kw_char(input int k, input int i);
        string s;
        case (k)
            0: s = "int8";     1: s = "int16";   2: s = "int32";   3: s = "int64";
            4: s = "float8";   5: s = "float16"; 6: s = "float32"; 7: s = "float64";
            8: s = "char";     9: s = "string";  10: s = "bool";   11: s = "if";
            12: s = "else";    13: s = "loop";   14: s = "fn";     15: s = "return";
            16: s = "true";    default: s = "false";
        endcase
        return (i < s.len()) ? s[i] : 8'd0;
    endfunction

    function automatic int kw_len(input int k);
        case (k)
            0: return 4;  1: return 5;  2: return 5;  3: return 5;  4: return 6;
            5: return 7;  6: return 7;  7: return 7;  8: return 4;  9: return 6;
            10: return 4; 11: return 2; 12: return 4; 13: return 4; 14: return 2;
            15: return 6; 16: return 4; default: return 5;
        endcase
    endfunction

    function automatic logic [5:0] word_kind(input t_prefix pre,
                                             input logic [LENGTH_BITS-1:0] len);
        logic [5:0] kind;
        logic       hit;
        kind = K_IDENT;
        for (int k = 0; k < 18; k++) begin
            hit = (len == LENGTH_BITS'(kw_len(k)));
            for (int i = 0; i < PREFIX_DEPTH; i++) begin
                if (i < kw_len(k) && pre[i*8 +: 8] != kw_char(k, i)) begin
                    hit = 1'b0;
                end
            end
            if (hit && kind == K_IDENT) begin
                kind = 6'(k);
            end
        end
        return kind;
    endfunction
endpackage
`default_nettype wire

[hdl/scl_front.sv]
// Front end of the lexer: scan state machine that classifies each byte and
// releases a burst of zero to three tokens per transaction. Uses scl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_char_byte,
    output logic               o_burst_valid,
    input  wire logic          i_burst_ready,
    output scl_pkg::t_burst    o_burst
);
    localparam logic [scl_pkg::LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [scl_pkg::LENGTH_BITS-1:0] LEN_ONE = scl_pkg::LENGTH_BITS'(1);
    localparam logic [scl_pkg::LENGTH_BITS-1:0] LEN_TWO = scl_pkg::LENGTH_BITS'(2);
    localparam logic [scl_pkg::DEPTH_BITS-1:0]  DEPTH_MAX = '1;
    localparam logic [scl_pkg::DEPTH_BITS-1:0]  DEPTH_ONE = scl_pkg::DEPTH_BITS'(1);

    scl_pkg::t_phase                  r_phase, n_phase;
    logic [scl_pkg::OFFSET_BITS-1:0]  r_pos, n_pos, r_begin, n_begin;
    logic [scl_pkg::LENGTH_BITS-1:0]  r_run, n_run;
    logic [scl_pkg::DEPTH_BITS-1:0]   r_depth, n_depth;
    scl_pkg::t_prefix                 r_prefix, n_prefix;
    logic                             r_bvalid;
    scl_pkg::t_burst                  r_burst, n_burst;

    logic        take;
    logic [7:0]  c;
    logic        is_dig, is_alp, used;
    logic [scl_pkg::OFFSET_BITS-1:0] prev;
    logic [scl_pkg::LENGTH_BITS-1:0] run_p1;
    logic [5:0]  single;
    logic [1:0]  cnt;

    assign o_ready = !r_bvalid || i_burst_ready;
    assign take = i_valid && o_ready;
    assign o_burst_valid = r_bvalid;
    assign o_burst = r_burst;
    assign c = i_char_byte;
    assign is_dig = (c >= "0") && (c <= "9");
    assign is_alp = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign prev = r_pos - 1'b1;
    assign run_p1 = (r_run == LEN_MAX) ? r_run : r_run + 1'b1;

    always_comb begin
        case (r_phase)
            scl_pkg::PH_PLUS:  single = scl_pkg::K_PLUS;
            scl_pkg::PH_MINUS: single = scl_pkg::K_MINUS;
            scl_pkg::PH_STAR:  single = scl_pkg::K_STAR;
            scl_pkg::PH_SLASH: single = scl_pkg::K_SLASH;
            scl_pkg::PH_DOT:   single = scl_pkg::K_DOT;
            scl_pkg::PH_EQ:    single = scl_pkg::K_EQ;
            scl_pkg::PH_BANG:  single = scl_pkg::K_BANG;
            scl_pkg::PH_LT:    single = scl_pkg::K_LT;
            scl_pkg::PH_GT:    single = scl_pkg::K_GT;
            default:           single = scl_pkg::K_ERROR;
        endcase
    end

    always_comb begin
        scl_pkg::t_token t [3];
        logic [1:0] rr;
        n_phase = r_phase; n_pos = r_pos; n_begin = r_begin; n_run = r_run;
        n_depth = r_depth; n_prefix = r_prefix;
        cnt = 2'd0; used = 1'b0; rr = 2'd0;
        for (int k = 0; k < 3; k++) begin
            t[k] = '0;
        end
        if (i_mode) begin
            case (r_phase)
                scl_pkg::PH_PLUS, scl_pkg::PH_MINUS, scl_pkg::PH_STAR, scl_pkg::PH_SLASH,
                scl_pkg::PH_DOT, scl_pkg::PH_EQ, scl_pkg::PH_BANG, scl_pkg::PH_LT,
                scl_pkg::PH_GT, scl_pkg::PH_AMP, scl_pkg::PH_PIPE: begin
                    t[0] = '{single, r_begin, LEN_ONE, 1'b0}; cnt = 2'd1;
                end
                scl_pkg::PH_STR, scl_pkg::PH_BLOCK, scl_pkg::PH_BLOCK_SLASH,
                scl_pkg::PH_BLOCK_STAR: begin
                    t[0] = '{scl_pkg::K_ERROR, r_begin, r_run, 1'b0}; cnt = 2'd1;
                end
                scl_pkg::PH_INT: begin
                    t[0] = '{scl_pkg::K_INT, r_begin, r_run, 1'b0}; cnt = 2'd1;
                end
                scl_pkg::PH_INT_DOT: begin
                    t[0] = '{scl_pkg::K_INT, r_begin, r_run, 1'b0};
                    t[1] = '{scl_pkg::K_DOT, prev, LEN_ONE, 1'b0}; cnt = 2'd2;
                end
                scl_pkg::PH_FLOAT: begin
                    t[0] = '{scl_pkg::K_FLOAT, r_begin, r_run, 1'b0}; cnt = 2'd1;
                end
                scl_pkg::PH_IDENT: begin
                    t[0] = '{scl_pkg::word_kind(r_prefix, r_run), r_begin, r_run, 1'b0};
                    cnt = 2'd1;
                end
                default: cnt = 2'd0;
            endcase
            t[cnt] = '{scl_pkg::K_END, r_pos, LEN_ONE, 1'b0};
            cnt = cnt + 2'd1;
            n_phase = scl_pkg::PH_IDLE; n_pos = '0; n_begin = '0; n_run = '0;
            n_depth = '0; n_prefix = '0;
        end else begin
            n_pos = r_pos + 1'b1;
            case (r_phase)
                scl_pkg::PH_PLUS, scl_pkg::PH_STAR, scl_pkg::PH_EQ, scl_pkg::PH_BANG,
                scl_pkg::PH_LT, scl_pkg::PH_GT: begin
                    n_phase = scl_pkg::PH_IDLE; cnt = 2'd1;
                    if (c == "=") begin
                        t[0] = '{single + 6'd1, r_begin, LEN_TWO, 1'b0}; used = 1'b1;
                    end else begin
                        t[0] = '{single, r_begin, LEN_ONE, 1'b0};
                    end
                end
                scl_pkg::PH_MINUS: begin
                    n_phase = scl_pkg::PH_IDLE; cnt = 2'd1;
                    if (c == "=") begin
                        t[0] = '{scl_pkg::K_MINUS + 6'd1, r_begin, LEN_TWO, 1'b0};
                        used = 1'b1;
                    end else if (c == ">") begin
                        t[0] = '{scl_pkg::K_ARROW, r_begin, LEN_TWO, 1'b0}; used = 1'b1;
                    end else begin
                        t[0] = '{scl_pkg::K_MINUS, r_begin, LEN_ONE, 1'b0};
                    end
                end
                scl_pkg::PH_SLASH: begin
                    used = 1'b1;
                    if (c == "/") begin
                        n_phase = scl_pkg::PH_LINE;
                    end else if (c == "*") begin
                        n_phase = scl_pkg::PH_BLOCK; n_depth = DEPTH_ONE; n_run = LEN_TWO;
                    end else if (c == "=") begin
                        n_phase = scl_pkg::PH_IDLE; cnt = 2'd1;
                        t[0] = '{scl_pkg::K_SLASH + 6'd1, r_begin, LEN_TWO, 1'b0};
                    end else begin
                        n_phase = scl_pkg::PH_IDLE; cnt = 2'd1; used = 1'b0;
                        t[0] = '{scl_pkg::K_SLASH, r_begin, LEN_ONE, 1'b0};
                    end
                end
                scl_pkg::PH_DOT: begin
                    n_phase = scl_pkg::PH_IDLE; cnt = 2'd1;
                    if (c == ".") begin
                        t[0] = '{scl_pkg::K_DOTDOT, r_begin, LEN_TWO, 1'b0}; used = 1'b1;
                    end else begin
                        t[0] = '{scl_pkg::K_DOT, r_begin, LEN_ONE, 1'b0};
                    end
                end
                scl_pkg::PH_AMP, scl_pkg::PH_PIPE: begin
                    n_phase = scl_pkg::PH_IDLE; cnt = 2'd1;
                    if (r_phase == scl_pkg::PH_AMP && c == "&") begin
                        t[0] = '{scl_pkg::K_ANDAND, r_begin, LEN_TWO, 1'b0}; used = 1'b1;
                    end else if (r_phase == scl_pkg::PH_PIPE && c == "|") begin
                        t[0] = '{scl_pkg::K_OROR, r_begin, LEN_TWO, 1'b0}; used = 1'b1;
                    end else begin
                        t[0] = '{scl_pkg::K_ERROR, r_begin, LEN_ONE, 1'b0};
                    end
                end
                scl_pkg::PH_STR: begin
                    used = 1'b1; n_run = run_p1;
                    if (c == "\"") begin
                        t[0] = '{scl_pkg::K_STRING, r_begin, run_p1, 1'b0}; cnt = 2'd1;
                        n_phase = scl_pkg::PH_IDLE;
                    end
                end
                scl_pkg::PH_INT: begin
                    if (is_dig) begin
                        used = 1'b1; n_run = run_p1;
                    end else if (c == ".") begin
                        used = 1'b1; n_phase = scl_pkg::PH_INT_DOT;
                    end else begin
                        t[0] = '{scl_pkg::K_INT, r_begin, r_run, 1'b0}; cnt = 2'd1;
                        n_phase = scl_pkg::PH_IDLE;
                    end
                end
                scl_pkg::PH_INT_DOT: begin
                    if (is_dig) begin
                        used = 1'b1; n_phase = scl_pkg::PH_FLOAT;
                        n_run = (run_p1 == LEN_MAX) ? run_p1 : run_p1 + 1'b1;
                    end else begin
                        t[0] = '{scl_pkg::K_INT, r_begin, r_run, 1'b0}; cnt = 2'd2;
                        n_phase = scl_pkg::PH_IDLE;
                        if (c == ".") begin
                            t[1] = '{scl_pkg::K_DOTDOT, prev, LEN_TWO, 1'b0}; used = 1'b1;
                        end else begin
                            t[1] = '{scl_pkg::K_DOT, prev, LEN_ONE, 1'b0};
                        end
                    end
                end
                scl_pkg::PH_FLOAT: begin
                    if (is_dig) begin
                        used = 1'b1; n_run = run_p1;
                    end else begin
                        t[0] = '{scl_pkg::K_FLOAT, r_begin, r_run, 1'b0}; cnt = 2'd1;
                        n_phase = scl_pkg::PH_IDLE;
                    end
                end
                scl_pkg::PH_IDENT: begin
                    if (is_alp || is_dig || c == "_") begin
                        used = 1'b1; n_run = run_p1;
                        for (int i = 1; i < scl_pkg::PREFIX_DEPTH; i++) begin
                            if (r_run == scl_pkg::LENGTH_BITS'(i)) begin
                                n_prefix[i*8 +: 8] = c;
                            end
                        end
                    end else begin
                        t[0] = '{scl_pkg::word_kind(r_prefix, r_run), r_begin, r_run, 1'b0};
                        cnt = 2'd1; n_phase = scl_pkg::PH_IDLE;
                    end
                end
                scl_pkg::PH_LINE: begin
                    used = 1'b1;
                    if (c == 8'h0a) begin
                        n_phase = scl_pkg::PH_IDLE;
                    end
                end
                scl_pkg::PH_BLOCK, scl_pkg::PH_BLOCK_SLASH, scl_pkg::PH_BLOCK_STAR: begin
                    used = 1'b1; n_run = run_p1;
                    if (r_phase == scl_pkg::PH_BLOCK_SLASH && c == "*") begin
                        if (r_depth != DEPTH_MAX) begin
                            n_depth = r_depth + 1'b1;
                        end
                        n_phase = scl_pkg::PH_BLOCK;
                    end else if (r_phase == scl_pkg::PH_BLOCK_STAR && c == "/") begin
                        n_depth = (r_depth != '0) ? r_depth - 1'b1 : r_depth;
                        n_phase = (n_depth == '0) ? scl_pkg::PH_IDLE : scl_pkg::PH_BLOCK;
                    end else if (c == "/") begin
                        n_phase = scl_pkg::PH_BLOCK_SLASH;
                    end else if (c == "*") begin
                        n_phase = scl_pkg::PH_BLOCK_STAR;
                    end else begin
                        n_phase = scl_pkg::PH_BLOCK;
                    end
                end
                default: begin
                    n_phase = scl_pkg::PH_IDLE;
                end
            endcase
            if (!used) begin
                n_begin = r_pos; n_run = LEN_ONE;
                rr = 2'd0;
                n_phase = scl_pkg::PH_IDLE;
                case (c)
                    8'h20, 8'h09, 8'h0d, 8'h0a: rr = 2'd0;
                    "+": n_phase = scl_pkg::PH_PLUS;
                    "-": n_phase = scl_pkg::PH_MINUS;
                    "*": n_phase = scl_pkg::PH_STAR;
                    "/": n_phase = scl_pkg::PH_SLASH;
                    ".": n_phase = scl_pkg::PH_DOT;
                    "=": n_phase = scl_pkg::PH_EQ;
                    "!": n_phase = scl_pkg::PH_BANG;
                    "<": n_phase = scl_pkg::PH_LT;
                    ">": n_phase = scl_pkg::PH_GT;
                    "&": n_phase = scl_pkg::PH_AMP;
                    "|": n_phase = scl_pkg::PH_PIPE;
                    "\"": n_phase = scl_pkg::PH_STR;
                    "(": begin t[cnt] = '{scl_pkg::K_LPAREN, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    ")": begin t[cnt] = '{scl_pkg::K_RPAREN, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    "{": begin t[cnt] = '{scl_pkg::K_LBRACE, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    "}": begin t[cnt] = '{scl_pkg::K_RBRACE, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    "[": begin
                        t[cnt] = '{scl_pkg::K_LBRACKET, r_pos, LEN_ONE, 1'b0}; rr = 2'd1;
                    end
                    "]": begin
                        t[cnt] = '{scl_pkg::K_RBRACKET, r_pos, LEN_ONE, 1'b0}; rr = 2'd1;
                    end
                    ",": begin t[cnt] = '{scl_pkg::K_COMMA, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    ";": begin t[cnt] = '{scl_pkg::K_SEMI, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    ":": begin t[cnt] = '{scl_pkg::K_COLON, r_pos, LEN_ONE, 1'b0}; rr = 2'd1; end
                    default: begin
                        if (is_dig) begin
                            n_phase = scl_pkg::PH_INT;
                        end else if (is_alp || c == "_") begin
                            n_phase = scl_pkg::PH_IDENT;
                            n_prefix[7:0] = c;
                        end else begin
                            t[cnt] = '{scl_pkg::K_ERROR, r_pos, LEN_ONE, 1'b0}; rr = 2'd1;
                        end
                    end
                endcase
                cnt = cnt + rr;
            end
        end
        if (cnt != 2'd0) begin
            t[cnt - 2'd1].last = 1'b1;
        end
        n_burst = '{cnt, t[0], t[1], t[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= scl_pkg::PH_IDLE;
            r_pos <= '0; r_begin <= '0; r_run <= '0; r_depth <= '0;
            r_bvalid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_pos <= n_pos; r_begin <= n_begin;
                r_run <= n_run; r_depth <= n_depth;
                r_bvalid <= (n_burst.count != 2'd0);
            end else if (i_burst_ready) begin
                r_bvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prefix <= n_prefix;
            r_burst <= n_burst;
        end
    end
endmodule
`default_nettype wire

[hdl/scl_back.sv]
// Back end of the lexer: token queue that unpacks bursts into single token
// transactions on the output channel. Uses scl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_burst_valid,
    output logic               o_burst_ready,
    input  wire scl_pkg::t_burst i_burst,
    output logic               o_valid,
    input  wire logic          i_ready,
    output scl_pkg::t_token    o_token
);
    localparam int QD = 4;
    scl_pkg::t_token r_q [QD];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt;
    logic       pop, push;
    scl_pkg::t_token tk [3];

    assign o_valid = (r_cnt != 3'd0);
    assign o_token = r_q[r_rd];
    assign pop = o_valid && i_ready;
    assign o_burst_ready = (r_cnt <= 3'd1);
    assign push = i_burst_valid && o_burst_ready;
    assign tk[0] = i_burst.tok0;
    assign tk[1] = i_burst.tok1;
    assign tk[2] = i_burst.tok2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_rd <= r_rd + 2'(pop);
            r_wr <= r_wr + (push ? i_burst.count : 2'd0);
            r_cnt <= r_cnt + (push ? 3'(i_burst.count) : 3'd0) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < i_burst.count) begin
                    r_q[r_wr + 2'(k)] <= tk[k];
                end
            end
        end
    end
endmodule
`default_nettype wire

[hdl/source_code_lexer_core.sv]
// Top level of the streaming source code lexer.
// Instantiates scl_front and scl_back; uses scl_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The lexer takes one source byte or end marker per transaction and returns
// tokens (kind, start offset, length, last flag). A new input is accepted every
// cycle while the token queue has room; a byte that releases two or three
// tokens at once sends them out one token per transaction, the limit set by the
// single-token output queue read port; tokens pass the burst register, then the queue.
module source_code_lexer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_char_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [5:0]       o_token_kind,
    output logic [31:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run
);
    logic            burst_valid, burst_ready;
    scl_pkg::t_burst burst;
    scl_pkg::t_token tok;

    scl_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_char_byte,
        .o_burst_valid(burst_valid), .i_burst_ready(burst_ready), .o_burst(burst)
    );
    scl_back u_back (
        .i_clk, .i_rst_n, .i_burst_valid(burst_valid), .o_burst_ready(burst_ready),
        .i_burst(burst), .o_valid, .i_ready, .o_token(tok)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_last_of_run  = tok.last;
endmodule
`default_nettype wire

[hdl/scl_checker.sv]
// Port checker for the lexer top level, attached by bind.
// Depends on the ports of source_code_lexer_core and on scl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        i_mode,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [5:0]  o_token_kind,
    input wire logic [15:0] o_token_length,
    input wire logic        o_last_of_run
);
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_kind <= scl_pkg::K_END) else $error("token kind out of range");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == scl_pkg::K_END |-> o_last_of_run && o_token_length == 16'd1)
        else $error("end token malformed");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind))
        else $error("output transaction dropped");
    a_end_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_mode |=> ##1 o_valid)
        else $error("end marker gave no token");
endmodule

bind source_code_lexer_core scl_checker u_scl_checker (.*);
`default_nettype wire
